@@ src/scanline_dp_disparity_macros.svh @@
// assertion macros for the scanline disparity block
// used by the rtl files that carry concurrent checks; needs a clk and rst in scope
`ifndef SCANLINE_DP_DISPARITY_MACROS_SVH
`define SCANLINE_DP_DISPARITY_MACROS_SVH

// same-cycle implication, checked outside reset
`define SDPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SDPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sdpd_pkg.sv @@
// shared constants and types for the scanline disparity block
// no dependencies; used by the cost unit, the trace store and the top level
`default_nettype none

package sdpd_pkg;

  localparam int ACC_W = 26;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam int COST_IN_W  = 16;
  localparam int OUT_COL_W  = 10;
  localparam int OUT_DISP_W = 6;
  localparam int OUT_DATA_W = OUT_COL_W + OUT_DISP_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_W_W    = 11;
  localparam int DISP_CNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_COUNT = 8'd1;

  localparam logic [ROW_W_W-1:0]    ROW_WIDTH_RESET  = 11'd640;
  localparam logic [DISP_CNT_W-1:0] DISP_COUNT_RESET = 7'd64;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [1:0] STEP_STAY = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  // control from the sequencer to the cost unit
  typedef struct packed {
    logic rd_en;      // read the previous-column bank
    logic load_mid;   // capture level 0 into the window
    logic calc;       // combine, write back and slide the window
    logic first_col;  // column 0: cost passes straight through
    logic has_lo;     // level d-1 exists
    logic has_hi;     // level d+1 exists
  } push_ctrl_t;

endpackage

`default_nettype wire

@@ src/sdpd_cost_unit.sv @@
// accumulated cost memory (two banks, previous and current column) with the
// three-neighbour minimum and saturating add; uses sdpd_pkg
`default_nettype none

module sdpd_cost_unit #(
  parameter int LV_W = 6
) (
  input  wire logic                     clk,
  input  wire sdpd_pkg::push_ctrl_t     ctrl,
  input  wire logic                     bank_cur,
  input  wire logic [LV_W-1:0]          rd_lv,
  input  wire logic [LV_W-1:0]          wr_lv,
  input  wire logic [sdpd_pkg::ACC_W-1:0] cost,
  output logic      [sdpd_pkg::ACC_W-1:0] acc,
  output logic      [1:0]               code
);

  localparam int DEPTH = 2 << LV_W;

  logic [sdpd_pkg::ACC_W-1:0] mem [DEPTH];
  logic [sdpd_pkg::ACC_W-1:0] rdata;
  logic [sdpd_pkg::ACC_W-1:0] win_lo;
  logic [sdpd_pkg::ACC_W-1:0] win_mid;
  logic [sdpd_pkg::ACC_W-1:0] best_nb;
  logic [sdpd_pkg::ACC_W:0]   sum;
  logic                       lo_wins;
  logic                       mid_wins;

  // reads go to the other bank, writes to the current one, so they never meet
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata <= mem[{~bank_cur, rd_lv}];
    end
    if (ctrl.calc) begin
      mem[{bank_cur, wr_lv}] <= acc;
    end
  end

  // window holds previous levels d-1 and d; the fresh read is d+1
  always_ff @(posedge clk) begin
    if (ctrl.load_mid) begin
      win_mid <= rdata;
    end else if (ctrl.calc) begin
      win_lo  <= win_mid;
      win_mid <= rdata;
    end
  end

  always_comb begin
    lo_wins  = ctrl.has_lo && (win_lo < win_mid) && (!ctrl.has_hi || (win_lo < rdata));
    mid_wins = !ctrl.has_hi || (win_mid < rdata);
    priority if (lo_wins) begin
      best_nb = win_lo;
      code    = sdpd_pkg::STEP_DOWN;
    end else if (mid_wins) begin
      best_nb = win_mid;
      code    = sdpd_pkg::STEP_STAY;
    end else begin
      best_nb = rdata;
      code    = sdpd_pkg::STEP_UP;
    end
    sum = {1'b0, cost} + {1'b0, best_nb};
    if (ctrl.first_col) begin
      acc  = cost;
      code = sdpd_pkg::STEP_STAY;
    end else if (sum[sdpd_pkg::ACC_W]) begin
      acc = sdpd_pkg::ACC_MAX;
    end else begin
      acc = sum[sdpd_pkg::ACC_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ src/sdpd_trace_store.sv @@
// step memory, one 2-bit step per column and level, and the backtrack step
// that moves the trace level; uses sdpd_pkg
`default_nettype none

module sdpd_trace_store #(
  parameter int COL_W = 10,
  parameter int LV_W  = 6,
  parameter int CL_W  = 7
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_col,
  input  wire logic [LV_W-1:0]  wr_lv,
  input  wire logic [1:0]       wr_code,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] trace_col,
  input  wire logic [LV_W-1:0]  trace_lv,
  input  wire logic [CL_W-1:0]  levels,
  output logic      [LV_W-1:0]  next_lv
);

  localparam int DEPTH = 1 << (COL_W + LV_W);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_code;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_col, wr_lv}] <= wr_code;
    end
    if (rd_en) begin
      rd_code <= mem[{trace_col, trace_lv}];
    end
  end

  // a step that would leave the level range is ignored
  always_comb begin
    next_lv = trace_lv;
    if (rd_code == sdpd_pkg::STEP_UP) begin
      if ((CL_W'(trace_lv) + CL_W'(1)) < levels) begin
        next_lv = trace_lv + LV_W'(1);
      end
    end else if (rd_code == sdpd_pkg::STEP_DOWN) begin
      if (trace_lv != '0) begin
        next_lv = trace_lv - LV_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/scanline_dp_disparity.sv @@
// top level of the scanline disparity block: sequencer, configuration, trace
// registers and output register; uses sdpd_pkg, sdpd_cost_unit, sdpd_trace_store
//
//   channel  dir  handshake                  payload
//   s_axis   in   s_axis_tvalid/tready       tdata: match_cost; tuser: op
//   m_axis   out  m_axis_tvalid/tready       tdata: column, disparity; tlast: last
//   cfg      in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// a push goes through the calc state, and at level 0 of every column after
// the first through a load state before it: the cost memory has one registered
// read port, and level 0 needs two previous-column reads before the window is
// full. a pull goes through the trace state (registered step memory read); a
// pull with no row ready stays idle and gives no item.
// synchronous reset clears control state; the cost and step memories are not
// cleared and need no pass, each entry being written before it is read.
// s_axis is held off while busy, while cfg_valid is high or while an unread item blocks the output.
`default_nettype none

module scanline_dp_disparity #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LEVELS = 64,
  parameter int COST_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [sdpd_pkg::COST_IN_W-1:0]     s_axis_tdata,  // [15:0] match_cost
  input  wire logic [0:0]                         s_axis_tuser,  // [0] op
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [sdpd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [9:0] column, [15:10] disparity
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sdpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sdpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `include "scanline_dp_disparity_macros.svh"

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LV_W  = $clog2(MAX_LEVELS);
  localparam int WC_W  = $clog2(MAX_WIDTH + 1);
  localparam int CL_W  = $clog2(MAX_LEVELS + 1);
  localparam logic [sdpd_pkg::ACC_W-1:0] COST_MASK =
    sdpd_pkg::ACC_W'((64'd1 << COST_BITS) - 64'd1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_CALC  = 2'd2;
  localparam logic [1:0] ST_TRACE = 2'd3;

  logic [1:0]                       state;
  logic [sdpd_pkg::ROW_W_W-1:0]     row_width;
  logic [sdpd_pkg::DISP_CNT_W-1:0]  disparity_count;
  logic [COL_W-1:0]                 load_column;
  logic [LV_W-1:0]                  load_level;
  logic [sdpd_pkg::ACC_W-1:0]       best_cost;
  logic [LV_W-1:0]                  trace_level;
  logic [COL_W-1:0]                 trace_column;
  logic                             row_ready;
  logic                             bank_cur;
  logic [sdpd_pkg::ACC_W-1:0]       cost_q;
  logic [sdpd_pkg::OUT_COL_W-1:0]   out_column;
  logic [sdpd_pkg::OUT_DISP_W-1:0]  out_disp;
  logic                             out_last;

  logic [WC_W-1:0]                  eff_width;
  logic [CL_W-1:0]                  eff_levels;
  logic                             in_accept;
  logic                             cfg_accept;
  logic                             col_last;
  logic                             lvl_last;
  logic                             row_start;
  logic [sdpd_pkg::ACC_W-1:0]       best_base;
  logic [LV_W-1:0]                  tl_base;
  logic [LV_W-1:0]                  rd_lv;
  logic [sdpd_pkg::ACC_W-1:0]       acc;
  logic [1:0]                       code;
  logic [LV_W-1:0]                  next_lv;
  sdpd_pkg::push_ctrl_t             ctrl;

  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid && (!m_axis_tvalid || m_axis_tready);
  assign cfg_ready     = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_accept    = cfg_valid && cfg_ready;
  assign m_axis_tdata  = {out_disp, out_column};
  assign m_axis_tlast  = out_last;

  // zero acts as one, values past the maximum act as the maximum
  always_comb begin
    if (row_width == '0) begin
      eff_width = WC_W'(1);
    end else if (32'(row_width) > MAX_WIDTH) begin
      eff_width = WC_W'(MAX_WIDTH);
    end else begin
      eff_width = WC_W'(row_width);
    end
    if (disparity_count == '0) begin
      eff_levels = CL_W'(1);
    end else if (32'(disparity_count) > MAX_LEVELS) begin
      eff_levels = CL_W'(MAX_LEVELS);
    end else begin
      eff_levels = CL_W'(disparity_count);
    end
  end

  always_comb begin
    col_last  = (WC_W'(load_column) + WC_W'(1)) == eff_width;
    lvl_last  = (CL_W'(load_level) + CL_W'(1)) == eff_levels;
    row_start = (load_column == '0) && (load_level == '0);
    best_base = row_start ? sdpd_pkg::ACC_MAX : best_cost;
    tl_base   = row_start ? '0 : trace_level;
    // in load read level 1; otherwise read ahead to d+1, or level 0 when a column starts
    if (state == ST_LOAD) begin
      rd_lv = LV_W'(1);
    end else if (load_level == '0) begin
      rd_lv = '0;
    end else begin
      rd_lv = load_level + LV_W'(1);
    end
    ctrl.rd_en     = (state == ST_IDLE) || (state == ST_LOAD);
    ctrl.load_mid  = (state == ST_LOAD);
    ctrl.calc      = (state == ST_CALC);
    ctrl.first_col = (load_column == '0);
    ctrl.has_lo    = (load_level != '0);
    ctrl.has_hi    = (CL_W'(load_level) + CL_W'(1)) < eff_levels;
  end

  sdpd_cost_unit #(
    .LV_W(LV_W)
  ) u_cost (
    .clk      (clk),
    .ctrl     (ctrl),
    .bank_cur (bank_cur),
    .rd_lv    (rd_lv),
    .wr_lv    (load_level),
    .cost     (cost_q),
    .acc      (acc),
    .code     (code)
  );

  sdpd_trace_store #(
    .COL_W(COL_W),
    .LV_W (LV_W),
    .CL_W (CL_W)
  ) u_trace (
    .clk       (clk),
    .wr_en     (state == ST_CALC),
    .wr_col    (load_column),
    .wr_lv     (load_level),
    .wr_code   (code),
    .rd_en     (state == ST_IDLE),
    .trace_col (trace_column),
    .trace_lv  (trace_level),
    .levels    (eff_levels),
    .next_lv   (next_lv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      row_width       <= sdpd_pkg::ROW_WIDTH_RESET;
      disparity_count <= sdpd_pkg::DISP_COUNT_RESET;
      load_column     <= '0;
      load_level      <= '0;
      best_cost       <= sdpd_pkg::ACC_MAX;
      trace_level     <= '0;
      trace_column    <= '0;
      row_ready       <= 1'b0;
      bank_cur        <= 1'b0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_accept) begin
            if (cfg_index == sdpd_pkg::CFG_ROW_WIDTH) begin
              row_width <= cfg_data[sdpd_pkg::ROW_W_W-1:0];
            end
            if (cfg_index == sdpd_pkg::CFG_DISP_COUNT) begin
              disparity_count <= cfg_data[sdpd_pkg::DISP_CNT_W-1:0];
            end
            // a known register drops the row in progress and any trace
            if ((cfg_index == sdpd_pkg::CFG_ROW_WIDTH) ||
                (cfg_index == sdpd_pkg::CFG_DISP_COUNT)) begin
              load_column  <= '0;
              load_level   <= '0;
              best_cost    <= sdpd_pkg::ACC_MAX;
              trace_level  <= '0;
              trace_column <= '0;
              row_ready    <= 1'b0;
            end
          end else if (in_accept) begin
            cost_q <= sdpd_pkg::ACC_W'(s_axis_tdata) & COST_MASK;
            if (s_axis_tuser[0] == sdpd_pkg::OP_PUSH) begin
              if ((load_column != '0) && (load_level == '0)) begin
                state <= ST_LOAD;
              end else begin
                state <= ST_CALC;
              end
            end else if (row_ready) begin
              state <= ST_TRACE;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          state <= ST_IDLE;
          if (col_last && (acc < best_base)) begin
            best_cost   <= acc;
            trace_level <= load_level;
          end else begin
            best_cost   <= best_base;
            trace_level <= tl_base;
          end
          if (lvl_last) begin
            load_level <= '0;
            bank_cur   <= ~bank_cur;
            if (col_last) begin
              load_column  <= '0;
              trace_column <= COL_W'(eff_width - WC_W'(1));
              row_ready    <= 1'b1;
            end else begin
              load_column <= load_column + COL_W'(1);
              if (row_start) begin
                row_ready <= 1'b0;
              end
            end
          end else begin
            load_level <= load_level + LV_W'(1);
            if (row_start) begin
              row_ready <= 1'b0;
            end
          end
        end
        ST_TRACE: begin
          state         <= ST_IDLE;
          m_axis_tvalid <= 1'b1;
          out_column    <= sdpd_pkg::OUT_COL_W'(trace_column);
          out_disp      <= sdpd_pkg::OUT_DISP_W'(trace_level);
          out_last      <= (trace_column == '0);
          trace_level   <= next_lv;
          if (trace_column == '0) begin
            row_ready <= 1'b0;
          end else begin
            trace_column <= trace_column - COL_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SDPD_ASSERT_NOW(a_trace_needs_row, state == ST_TRACE, row_ready, "trace step without a ready row")
  `SDPD_ASSERT_NOW(a_trace_out_free, state == ST_TRACE, !m_axis_tvalid, "output item would be overwritten")
  `SDPD_ASSERT_NOW(a_load_in_range, state == ST_CALC, (CL_W'(load_level) < eff_levels) && (WC_W'(load_column) < eff_width), "load position outside the row")
  `SDPD_ASSERT_NOW(a_load_only_col_start, state == ST_LOAD, (load_level == '0) && (load_column != '0), "window fill outside a column start")
  `SDPD_ASSERT_NEXT(a_pull_no_row_idle, in_accept && (s_axis_tuser[0] == sdpd_pkg::OP_PULL) && !row_ready, (state == ST_IDLE) && !m_axis_tvalid, "pull without a row gave an item")

endmodule

`default_nettype wire
